// ----- rtl/audio_level_meter_ballistics_top_assert.svh -----
// Assertion macros used by the level meter controller.
`ifndef AUDIO_LEVEL_METER_BALLISTICS_TOP_ASSERT_SVH
`define AUDIO_LEVEL_METER_BALLISTICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ALMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ALMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/almb_pkg.sv -----
// Types and constants shared by the level meter modules.
`timescale 1ns / 1ps
package almb_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GR_W      = 16;
  localparam int GRO_W     = 15;
  localparam int COEF_W    = 17;
  localparam int LVL_W     = 32;
  localparam int DB_W      = 16;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int SQR_STEPS  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_ATT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_REL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_ATT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_REL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GR_ATT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GR_REL   = 3'd5;

  typedef logic [COEF_W-1:0] coef_t;
  localparam coef_t REG_RESET [NUM_REGS] = '{
    17'd20972, 17'd2949, 17'd9437, 17'd1032, 17'd29491, 17'd3604
  };
  localparam coef_t COEF_ONE = 17'h10000;

  // smoothed channel selects
  typedef logic [1:0] chan_t;
  localparam chan_t CH_PEAK = 2'd0;
  localparam chan_t CH_RMS  = 2'd1;
  localparam chan_t CH_TP   = 2'd2;
  localparam chan_t CH_GR   = 2'd3;

  // below this level (1e-6 of full scale) the dB value is floored
  localparam logic [LVL_W-1:0] FLOOR_LIMIT   = 32'd2148;
  localparam logic [16:0]      DB_FLOOR_Q8   = 17'd30720;
  localparam logic [31:0]      DB_PER_LOG2   = 32'd394566;
  localparam logic [40:0]      DB_ROUND_HALF = 41'h800000;

  typedef struct packed {
    logic  load;
    logic  sq;
    logic  div_init;
    logic  div_step;
    logic  sqrt_init;
    logic  sqrt_step;
    logic  sm_mul;
    logic  sm_apply;
    logic  clr;
    logic  db_load;
    logic  db_norm;
    logic  db_sq;
    logic  db_mul;
    logic  db_store;
    logic  out_load;
    chan_t ch;
  } almb_cmd_t;

  typedef struct packed {
    logic last;
    logic db_special;
    logic db_norm_done;
  } almb_stat_t;

endpackage

// ----- rtl/almb_ctrl.sv -----
// Sequencer for per-sample accumulation and the end-of-block math.
`timescale 1ns / 1ps
module almb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  almb_pkg::almb_stat_t stat,
  output almb_pkg::almb_cmd_t  cmd
);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_SQ   = 15'b000000000000010,
    ST_ADD  = 15'b000000000000100,
    ST_DIVI = 15'b000000000001000,
    ST_DIV  = 15'b000000000010000,
    ST_SQI  = 15'b000000000100000,
    ST_SQRT = 15'b000000001000000,
    ST_SMA  = 15'b000000010000000,
    ST_SMB  = 15'b000000100000000,
    ST_DBL  = 15'b000001000000000,
    ST_DBN  = 15'b000010000000000,
    ST_DBS  = 15'b000100000000000,
    ST_DBM  = 15'b001000000000000,
    ST_DBR  = 15'b010000000000000,
    ST_OUT  = 15'b100000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  almb_pkg::chan_t      idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.ch    = idx_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = stat.last ? ST_ADD : ST_IDLE;
      end
      ST_ADD: begin
        // datapath folds the last square into the sum here
        state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == 7'(almb_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_SQI;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == 7'(almb_pkg::SQRT_STEPS - 1)) begin
          idx_nxt   = almb_pkg::CH_PEAK;
          state_nxt = ST_SMA;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_SMA: begin
        cmd.sm_mul = 1'b1;
        state_nxt  = ST_SMB;
      end
      ST_SMB: begin
        cmd.sm_apply = 1'b1;
        if (idx_r == almb_pkg::CH_GR) begin
          cmd.clr   = 1'b1;
          idx_nxt   = almb_pkg::CH_PEAK;
          state_nxt = ST_DBL;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_SMA;
        end
      end
      ST_DBL: begin
        cmd.db_load = 1'b1;
        state_nxt   = ST_DBN;
      end
      ST_DBN: begin
        if (stat.db_special) begin
          state_nxt = ST_DBR;
        end else if (stat.db_norm_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_DBS;
        end else begin
          cmd.db_norm = 1'b1;
        end
      end
      ST_DBS: begin
        cmd.db_sq = 1'b1;
        if (cnt_r == 7'(almb_pkg::SQR_STEPS - 1)) begin
          state_nxt = ST_DBM;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_DBM: begin
        cmd.db_mul = 1'b1;
        state_nxt  = ST_DBR;
      end
      ST_DBR: begin
        cmd.db_store = 1'b1;
        if (idx_r == almb_pkg::CH_TP) begin
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_DBL;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= almb_pkg::CH_PEAK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`include "audio_level_meter_ballistics_top_assert.svh"

  `ALMB_ASSERT_NEXT(a_accept_to_sq, in_tvalid && in_tready, state_r == ST_SQ, "accepted transaction not processed")
  `ALMB_ASSERT_NEXT(a_last_to_add, state_r == ST_SQ && stat.last, state_r == ST_ADD, "block end missed")
  `ALMB_ASSERT_NEXT(a_out_hold, state_r == ST_OUT && out_valid_r && !out_tready, state_r == ST_OUT && out_tvalid, "result slot overwritten")
  `ALMB_ASSERT_NOW(a_div_cnt, state_r == ST_DIV, cnt_r < 7'(almb_pkg::DIV_STEPS), "divide step count overrun")

endmodule

// ----- rtl/almb_datapath.sv -----
// Accumulators, shared multiplier, divide/root/log units and output register.
`timescale 1ns / 1ps
module almb_datapath #(
  parameter int MAX_SAMPLES = 65536,
  parameter int CNT_W       = 17
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [almb_pkg::SAMPLE_W-1:0]          sample_value,
  input  logic                                   channel_first,
  input  logic                                   block_last,
  input  logic [almb_pkg::GR_W-1:0]              gain_reduction_in,
  input  logic                                   cfg_we,
  input  logic [almb_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [almb_pkg::COEF_W-1:0]            cfg_wdata,
  input  almb_pkg::almb_cmd_t                    cmd,
  output almb_pkg::almb_stat_t                   stat,
  output logic [almb_pkg::SAMPLE_W-1:0]          peak_level,
  output logic [almb_pkg::SAMPLE_W-1:0]          rms_level,
  output logic [almb_pkg::SAMPLE_W-1:0]          true_peak_level,
  output logic [almb_pkg::DB_W-1:0]              peak_db,
  output logic [almb_pkg::DB_W-1:0]              rms_db,
  output logic [almb_pkg::DB_W-1:0]              true_peak_db,
  output logic [almb_pkg::GRO_W-1:0]             gain_reduction_out
);

  localparam int SW = almb_pkg::SAMPLE_W;

  // input holding
  logic signed [SW-1:0] s_r;
  logic                 first_r, last_r;
  logic [15:0]          gr_r;

  // block accumulators
  logic [SW-1:0]        peak_r, tpk_r;
  logic [63:0]          sum_r;
  logic [CNT_W-1:0]     count_r;
  logic signed [SW-1:0] prev_r;
  logic                 pend_r;

  // arithmetic state
  logic [63:0]          mprod_r;
  logic [63:0]          q_r;
  logic [CNT_W-1:0]     drem_r;
  logic [33:0]          srem_r;
  logic [31:0]          root_r;
  logic                 up_r;
  logic [31:0]          sm_peak_r, sm_rms_r, sm_tp_r, sm_gr_r;
  logic [31:0]          m_r;
  logic [4:0]           sh_r;
  logic [15:0]          frac_r;
  logic                 dbf_floor_r, dbf_top_r;
  logic [15:0]          db_peak_r, db_rms_r, db_tp_r;
  almb_pkg::coef_t      cfg_r [almb_pkg::NUM_REGS];

  // output register
  logic [SW-1:0]        o_peak_r, o_rms_r, o_tp_r;
  logic [15:0]          o_pdb_r, o_rdb_r, o_tdb_r;
  logic [14:0]          o_gr_r;

  function automatic logic [SW-1:0] interp_mag(input logic signed [SW+2:0] x);
    logic [SW+2:0] u;
    u = x[SW+2] ? (~x + 1'b1) : x;
    return u[SW+1:2];
  endfunction

  function automatic almb_pkg::coef_t coef_clamp(input almb_pkg::coef_t c);
    return c[almb_pkg::COEF_W-1] ? almb_pkg::COEF_ONE : c;
  endfunction

  // per-sample terms
  logic signed [SW-1:0] p_eff;
  logic signed [SW:0]   s_ext;
  logic [SW:0]          a_full;
  logic [SW-1:0]        a_mag;
  logic signed [SW+2:0] p27, s27;
  logic [SW-1:0]        i1, i2, i3, tp_cand;
  logic                 cnt_ok;

  always_comb begin
    p_eff  = first_r ? s_r : prev_r;
    s_ext  = {s_r[SW-1], s_r};
    a_full = s_ext[SW] ? (~s_ext + 1'b1) : s_ext;
    a_mag  = a_full[SW-1:0];
    p27    = {{3{p_eff[SW-1]}}, p_eff};
    s27    = {{3{s_r[SW-1]}}, s_r};
    i1     = interp_mag((p27 <<< 1) + p27 + s27);
    i2     = interp_mag((p27 + s27) <<< 1);
    i3     = interp_mag(p27 + (s27 <<< 1) + s27);
    tp_cand = a_mag;
    if (i1 > tp_cand) tp_cand = i1;
    if (i2 > tp_cand) tp_cand = i2;
    if (i3 > tp_cand) tp_cand = i3;
    cnt_ok = count_r < CNT_W'(MAX_SAMPLES);
  end

  // smoothing operand selection
  logic [31:0]     cur, tgt, grt, diff, step, lvl;
  almb_pkg::coef_t att, rel, coef;
  logic            up;

  always_comb begin
    grt = (!gr_r[15] && gr_r != 16'd0) ? {1'b0, gr_r[14:0], 16'h0000} : 32'd0;
    case (cmd.ch)
      almb_pkg::CH_PEAK: begin
        cur = sm_peak_r; tgt = {peak_r, 8'h00};
        att = cfg_r[almb_pkg::REG_PEAK_ATT]; rel = cfg_r[almb_pkg::REG_PEAK_REL];
        lvl = sm_peak_r;
      end
      almb_pkg::CH_RMS: begin
        cur = sm_rms_r; tgt = {root_r[SW-1:0], 8'h00};
        att = cfg_r[almb_pkg::REG_RMS_ATT]; rel = cfg_r[almb_pkg::REG_RMS_REL];
        lvl = sm_rms_r;
      end
      almb_pkg::CH_TP: begin
        cur = sm_tp_r; tgt = {tpk_r, 8'h00};
        att = cfg_r[almb_pkg::REG_PEAK_ATT]; rel = cfg_r[almb_pkg::REG_PEAK_REL];
        lvl = sm_tp_r;
      end
      default: begin
        cur = sm_gr_r; tgt = grt;
        att = cfg_r[almb_pkg::REG_GR_ATT]; rel = cfg_r[almb_pkg::REG_GR_REL];
        lvl = sm_peak_r;
      end
    endcase
    up   = tgt > cur;
    diff = up ? (tgt - cur) : (cur - tgt);
    coef = coef_clamp(up ? att : rel);
    step = mprod_r[47:16];
  end

  // the one multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mres;
  logic [21:0] neg;

  always_comb begin
    neg   = {6'(sh_r) + 6'd1, 16'h0000} - 22'(frac_r);
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq) begin
      mul_a = 32'(a_mag);
      mul_b = 32'(a_mag);
    end else if (cmd.sm_mul) begin
      mul_a = diff;
      mul_b = 32'(coef);
    end else if (cmd.db_sq) begin
      mul_a = m_r;
      mul_b = m_r;
    end else if (cmd.db_mul) begin
      mul_a = 32'(neg);
      mul_b = almb_pkg::DB_PER_LOG2;
    end
    mres = mul_a * mul_b;
  end

  // divide and root steps, sum folding and dB value rounding
  logic [CNT_W:0]  dsh;
  logic [35:0]     ssh, strial;
  logic [64:0]     sum_add;
  logic [31:0]     sq_t;
  logic [40:0]     rnd;
  logic [16:0]     mag;
  logic [15:0]     db_val;

  always_comb begin
    dsh     = {drem_r, q_r[63]};
    ssh     = {srem_r, q_r[63:62]};
    strial  = {2'b00, root_r, 2'b01};
    sum_add = {1'b0, sum_r} + {1'b0, mprod_r};
    sq_t    = mres[61:30];
    rnd     = mprod_r[40:0] + almb_pkg::DB_ROUND_HALF;
    mag     = rnd[40:24];
    if (mag > almb_pkg::DB_FLOOR_Q8) mag = almb_pkg::DB_FLOOR_Q8;
    if (dbf_floor_r) begin
      db_val = 16'h0000 - almb_pkg::DB_FLOOR_Q8[15:0];
    end else if (dbf_top_r) begin
      db_val = 16'h0000;
    end else begin
      db_val = 16'h0000 - mag[15:0];
    end
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r    <= '0;
      tpk_r     <= '0;
      sum_r     <= '0;
      count_r   <= '0;
      prev_r    <= '0;
      pend_r    <= 1'b0;
      sm_peak_r <= '0;
      sm_rms_r  <= '0;
      sm_tp_r   <= '0;
      sm_gr_r   <= '0;
      for (int i = 0; i < almb_pkg::NUM_REGS; i++) cfg_r[i] <= almb_pkg::REG_RESET[i];
    end else begin
      if (cfg_we && cfg_idx < almb_pkg::CFG_IDX_W'(almb_pkg::NUM_REGS)) begin
        cfg_r[cfg_idx] <= cfg_wdata;
      end
      pend_r <= 1'b0;
      if (cmd.sq) begin
        if (a_mag > peak_r) peak_r <= a_mag;
        if (tp_cand > tpk_r) tpk_r <= tp_cand;
        prev_r <= s_r;
        if (cnt_ok) begin
          count_r <= count_r + 1'b1;
          pend_r  <= 1'b1;
        end
      end
      if (pend_r) begin
        sum_r <= sum_add[64] ? '1 : sum_add[63:0];
      end
      if (cmd.sm_apply) begin
        case (cmd.ch)
          almb_pkg::CH_PEAK: sm_peak_r <= up_r ? cur + step : cur - step;
          almb_pkg::CH_RMS:  sm_rms_r  <= up_r ? cur + step : cur - step;
          almb_pkg::CH_TP:   sm_tp_r   <= up_r ? cur + step : cur - step;
          default:           sm_gr_r   <= up_r ? cur + step : cur - step;
        endcase
      end
      if (cmd.clr) begin
        peak_r  <= '0;
        tpk_r   <= '0;
        sum_r   <= '0;
        count_r <= '0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r     <= sample_value;
      first_r <= channel_first;
      last_r  <= block_last;
      gr_r    <= gain_reduction_in;
    end
    if (cmd.sq || cmd.sm_mul || cmd.db_mul) mprod_r <= mres;
    if (cmd.sm_mul) up_r <= up;
    if (cmd.div_init) begin
      q_r    <= sum_r;
      drem_r <= '0;
    end
    if (cmd.div_step) begin
      if (dsh >= {1'b0, count_r}) begin
        drem_r <= CNT_W'(dsh - {1'b0, count_r});
        q_r    <= {q_r[62:0], 1'b1};
      end else begin
        drem_r <= dsh[CNT_W-1:0];
        q_r    <= {q_r[62:0], 1'b0};
      end
    end
    if (cmd.sqrt_init) begin
      srem_r <= '0;
      root_r <= '0;
      if (count_r == '0) q_r <= '0;
    end
    if (cmd.sqrt_step) begin
      q_r <= {q_r[61:0], 2'b00};
      if (ssh >= strial) begin
        srem_r <= 34'(ssh - strial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        srem_r <= ssh[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.db_load) begin
      m_r         <= lvl[31] ? (lvl >> 1) : lvl;
      sh_r        <= '0;
      frac_r      <= '0;
      dbf_floor_r <= lvl < almb_pkg::FLOOR_LIMIT;
      dbf_top_r   <= lvl[31];
    end
    if (cmd.db_norm) begin
      m_r  <= m_r << 1;
      sh_r <= sh_r + 5'd1;
    end
    if (cmd.db_sq) begin
      m_r    <= sq_t[31] ? (sq_t >> 1) : sq_t;
      frac_r <= {frac_r[14:0], sq_t[31]};
    end
    if (cmd.db_store) begin
      case (cmd.ch)
        almb_pkg::CH_PEAK: db_peak_r <= db_val;
        almb_pkg::CH_RMS:  db_rms_r  <= db_val;
        default:           db_tp_r   <= db_val;
      endcase
    end
    if (cmd.out_load) begin
      o_peak_r <= sm_peak_r[SW+7:8];
      o_rms_r  <= sm_rms_r[SW+7:8];
      o_tp_r   <= sm_tp_r[SW+7:8];
      o_pdb_r  <= db_peak_r;
      o_rdb_r  <= db_rms_r;
      o_tdb_r  <= db_tp_r;
      o_gr_r   <= sm_gr_r[30:16];
    end
  end

  assign stat.last         = last_r;
  assign stat.db_special   = dbf_floor_r | dbf_top_r;
  assign stat.db_norm_done = m_r[30];

  assign peak_level         = o_peak_r;
  assign rms_level          = o_rms_r;
  assign true_peak_level    = o_tp_r;
  assign peak_db            = o_pdb_r;
  assign rms_db             = o_rdb_r;
  assign true_peak_db       = o_tdb_r;
  assign gain_reduction_out = o_gr_r;

endmodule

// ----- rtl/audio_level_meter_ballistics_top.sv -----
// Top level of the peak / RMS / true-peak level meter.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one audio sample per transaction. in_tuser marks a channel's first
//           sample, in_tlast the block's last sample (its gain reduction is used).
//   out_* : one result per block, sent after the block's last sample.
//   cfg_* : coefficient writes, taken every cycle; write only while idle.
// Flow: each sample is accepted in the idle state, then accumulated through
//   the shared multiplier before the next one is taken. A block's last sample
//   then holds the input while the sum is closed, for 64 divide steps, 32 root
//   steps, smoothing of four channels, three dB conversions (a level at the floor
//   or at full scale goes straight to the store, others take normalize shifts and
//   16 log squarings through the same multiplier) and the load of the result.
// Output: out_tvalid is registered and rises together with the loaded result.
// Reset (rst_n low, synchronous): accumulators, smoothed levels and the
//   coefficient registers return to their defaults; no result is pending.
// Stall: a finished result sits in the output register; the next block
//   is accepted meanwhile and only its own result waits for out_tready.
module audio_level_meter_ballistics_top #(
  parameter int MAX_BLOCK_SAMPLES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // sample_value[23:0], gain_reduction_in[39:24]
  input  logic         in_tuser,   // channel_first
  input  logic         in_tlast,   // block_last
  output logic         out_tvalid,
  input  logic         out_tready,
  // peak_level[23:0], rms_level[47:24], true_peak_level[71:48], peak_db[87:72],
  // rms_db[103:88], true_peak_db[119:104], gain_reduction_out[134:120], zero pad
  output logic [135:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);

  almb_pkg::almb_cmd_t  cmd;
  almb_pkg::almb_stat_t stat;

  logic [23:0] peak_level, rms_level, true_peak_level;
  logic [15:0] peak_db, rms_db, true_peak_db;
  logic [14:0] gain_reduction_out;

  assign cfg_ready = 1'b1;

  almb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  almb_datapath #(
    .MAX_SAMPLES (MAX_BLOCK_SAMPLES),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .sample_value       (in_tdata[23:0]),
    .channel_first      (in_tuser),
    .block_last         (in_tlast),
    .gain_reduction_in  (in_tdata[39:24]),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_idx            (cfg_index),
    .cfg_wdata          (cfg_data),
    .cmd                (cmd),
    .stat               (stat),
    .peak_level         (peak_level),
    .rms_level          (rms_level),
    .true_peak_level    (true_peak_level),
    .peak_db            (peak_db),
    .rms_db             (rms_db),
    .true_peak_db       (true_peak_db),
    .gain_reduction_out (gain_reduction_out)
  );

  assign out_tdata = {1'b0, gain_reduction_out, true_peak_db, rms_db, peak_db,
                      true_peak_level, rms_level, peak_level};

endmodule
